// ===== design/assert_macros.svh =====
// assertion macros used by the row engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SDRM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("row engine assertion failed");
// expression must never be true out of reset
`define SDRM_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("row engine forbidden condition seen");
`else
`define SDRM_ASSERT(label, prop)
`define SDRM_NEVER(label, expr)
`endif

`endif

// ===== design/sdrm_pkg.sv =====
// shared types, constants and saturation helpers of the row engine
`timescale 1ns / 1ps
`default_nettype none

package sdrm_pkg;

	localparam int COLS_DEF       = 16;
	localparam int DENSE_ROWS_DEF = 1024;
	localparam int DATA_W         = 16;
	localparam int COEF_W         = 32;
	localparam int ACC_W          = 48;
	localparam int OUT_W          = 32;
	localparam int FRAC_SHIFT     = 8;

	// request codes
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_NZ    = 2'd1,
		REQ_CLOSE = 2'd2
	} req_t;

	// configuration register indexes
	localparam logic CFG_SCALE = 1'b0;
	localparam logic CFG_COLS  = 1'b1;

	// controls broadcast to every cell
	typedef struct packed {
		logic rd_en;
		logic mac;
		logic shift;
	} cell_ctl_t;

	// clamp a grown sum back into the accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
		logic signed [ACC_W-1:0] r;
		if (s[ACC_W] != s[ACC_W-1]) begin
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = s[ACC_W-1:0];
		end
		return r;
	endfunction

	// clamp an accumulator to the output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
		logic signed [OUT_W-1:0] r;
		if ((&a[ACC_W-1:OUT_W-1]) || !(|a[ACC_W-1:OUT_W-1])) begin
			r = a[OUT_W-1:0];
		end else begin
			r = a[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/sparse_dense_row_mac.sv =====
// top level of the dense-times-sparse row engine
//
// Command interface: an item is taken when start is high and busy is low.
// A load item writes one dense element. For a nonzero item the dense row
// is read from the per-column stores with a registered read, then every column
// cell multiplies it in parallel; the accumulate stage overlaps the next item.
// A close item holds busy while the accumulators of all COLS cells shift
// one column per cycle down the cell chain toward the output, which also clears
// them. Its results come one per cycle, one for each used column, and each is
// marked by result_valid for a single cycle; the receiver cannot stall,
// so it must take every beat as it appears. The dense store is not cleared
// at reset and must be loaded before it is used.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sparse_dense_row_mac
	import sdrm_pkg::*;
#(
	parameter int COLS       = COLS_DEF,
	parameter int DENSE_ROWS = DENSE_ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command channel
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         req_type,
	input  wire logic [9:0]         dense_row,
	input  wire logic [3:0]         dense_col,
	input  wire logic signed [15:0] dense_value,
	input  wire logic [9:0]         nz_index,
	input  wire logic signed [15:0] nz_value,
	input  wire logic signed [15:0] row_weight,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [4:0]         cfg_wdata,
	// result channel
	output logic                    result_valid,
	output logic [15:0]             out_row,
	output logic [3:0]              out_col,
	output logic signed [31:0]      out_value,
	output logic                    last
);

	localparam int AW    = (DENSE_ROWS > 1) ? $clog2(DENSE_ROWS) : 1;
	localparam int CNT_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int NW    = $clog2(COLS + 1);

	logic                     scale_q;
	logic [4:0]               cols_q;
	logic [NW-1:0]            used;
	logic                     accept;
	logic                     do_load;
	logic                     do_nz;
	logic                     do_close;
	logic                     valid_s1;
	logic                     valid_s2;
	logic signed [COEF_W-1:0] nz_ext;
	logic signed [COEF_W-1:0] wgt_ext;
	logic signed [COEF_W-1:0] coef_s1;
	logic                     emit_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [15:0]              row_q;
	logic                     emit_end;
	cell_ctl_t                ctl;
	logic signed [ACC_W-1:0]  acc_w [COLS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 1'b0;
			cols_q  <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCALE: scale_q <= cfg_wdata[0];
				CFG_COLS:  cols_q  <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// clamp the column count to 1..COLS
	always_comb begin
		if (int'(cols_q) > COLS) begin
			used = NW'(COLS);
		end else if (cols_q == 5'd0) begin
			used = NW'(1);
		end else begin
			used = NW'(cols_q);
		end
	end

	// command decode
	assign busy     = valid_s1 || emit_q;
	assign accept   = start && !busy;
	assign do_load  = accept && (req_type == REQ_LOAD) && (int'(dense_row) < DENSE_ROWS)
		&& (int'(dense_col) < COLS);
	assign do_nz    = accept && (req_type == REQ_NZ) && (int'(nz_index) < DENSE_ROWS);
	assign do_close = accept && (req_type == REQ_CLOSE);

	// nonzero pipeline: coefficient and read at s1, product at s2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= do_nz;
			valid_s2 <= valid_s1;
		end
	end

	// sign-extended operands of the coefficient
	assign nz_ext  = COEF_W'(nz_value);
	assign wgt_ext = COEF_W'(row_weight);

	always_ff @(posedge clk) begin
		if (do_nz) begin
			coef_s1 <= scale_q ? nz_ext * wgt_ext : nz_ext <<< FRAC_SHIFT;
		end
	end

	// emit sequencer walks every cell so all accumulators are cleared
	assign emit_end = emit_q && (cnt_q == CNT_W'(COLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			cnt_q  <= '0;
			row_q  <= '0;
		end else if (do_close) begin
			emit_q <= 1'b1;
			cnt_q  <= '0;
		end else if (emit_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (emit_end) begin
				emit_q <= 1'b0;
				row_q  <= row_q + 16'd1;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit_q && (32'(cnt_q) < 32'(used));
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q) begin
			out_row   <= row_q;
			out_col   <= 4'(cnt_q);
			out_value <= sat_out(acc_w[0]);
			last      <= (32'(cnt_q) + 32'd1 == 32'(used));
		end
	end

	// cell controls
	always_comb begin
		ctl.rd_en = do_nz;
		ctl.mac   = valid_s2;
		ctl.shift = emit_q;
	end

	// chain of column cells, shifting toward cell zero
	assign acc_w[COLS] = '0;

	for (genvar j = 0; j < COLS; j++) begin : g_cell
		sdrm_cell #(
			.DENSE_ROWS(DENSE_ROWS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.col_used(int'(used) > j),
			.wr_en   (do_load && (int'(dense_col) == j)),
			.wr_addr (AW'(dense_row)),
			.wr_data (dense_value),
			.rd_addr (AW'(nz_index)),
			.coef    (coef_s1),
			.acc_in  (acc_w[j+1]),
			.acc     (acc_w[j])
		);
	end

	// assertions
	`SDRM_NEVER(a_mac_during_emit, valid_s2 && emit_q)
	`SDRM_ASSERT(a_beat_from_emit, result_valid |-> $past(emit_q))
	`SDRM_ASSERT(a_close_holds_busy, do_close |=> busy)
	`SDRM_ASSERT(a_row_advance, emit_end |=> (row_q == $past(row_q) + 16'd1))

endmodule

`default_nettype wire

// ===== design/sdrm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sdrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/sdrm_cell.sv =====
// one column cell: dense column slice, multiplier and accumulator on the shift chain
`timescale 1ns / 1ps
`default_nettype none

module sdrm_cell
	import sdrm_pkg::*;
#(
	parameter int DENSE_ROWS = DENSE_ROWS_DEF,
	localparam int AW = (DENSE_ROWS > 1) ? $clog2(DENSE_ROWS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cell_ctl_t               ctl,
	input  wire logic                    col_used,
	input  wire logic                    wr_en,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire logic [DATA_W-1:0]       wr_data,
	input  wire logic [AW-1:0]           rd_addr,
	input  wire logic signed [COEF_W-1:0] coef,
	input  wire logic signed [ACC_W-1:0] acc_in,
	output logic signed [ACC_W-1:0]      acc
);

	logic [DATA_W-1:0]        rd_raw;
	logic signed [DATA_W-1:0] rd_data;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W-1:0]  acc_q;

	// this cell's column of the dense store
	sdrm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DENSE_ROWS)
	) u_col_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (ctl.rd_en),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	assign rd_data = $signed(rd_raw);

	// coefficient times dense element, Q24.24 or Q16.24
	always_ff @(posedge clk) begin
		prod_s2 <= coef * rd_data;
	end

	// floor back to Q32.16 and add with saturation
	assign term = prod_s2 >>> FRAC_SHIFT;
	assign sum  = $signed({acc_q[ACC_W-1], acc_q}) + $signed({term[ACC_W-1], term});

	// accumulator: shifts toward cell zero on emit, accumulates on mac in a used column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= acc_in;
		end else if (ctl.mac && col_used) begin
			acc_q <= sat_acc(sum);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
